// File: rtl/mtuuid_pkg.sv
// Package for the MT19937 word and UUID generator.
// Holds the fixed sizes, seeding and tempering constants, request codes and the tempering function.
// Used by mt19937_uuid_v4_generator.
`timescale 1ns / 1ps
package mtuuid_pkg;

  // Fixed sizes of the twister state.
  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned SHIFT_OFFSET = 397;
  localparam int unsigned TW_AW        = 10;
  localparam int unsigned KEY_DEPTH_DEF = 1024;

  // Field widths.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned KLEN_W = 11;

  // Request codes.
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_SEED = 2'd1;
  localparam logic [1:0] FUNC_WORD = 2'd2;
  localparam logic [1:0] FUNC_UUID = 2'd3;

  // Seeding multipliers.
  localparam logic [31:0] MUL_LINEAR = 32'd1812433253;
  localparam logic [31:0] MUL_KEY    = 32'd1664525;
  localparam logic [31:0] MUL_MIX    = 32'd1566083941;

  // Twist and tempering constants.
  localparam logic [31:0] TWIST_A   = 32'h9908b0df;
  localparam logic [31:0] HEAD_WORD = 32'h80000000;
  localparam logic [31:0] TEMPER_B  = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C  = 32'hefc60000;
  localparam logic [KLEN_W-1:0] KLEN_RST = 11'd1000;

  // Output tempering of one state word.
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: rtl/mt19937_uuid_v4_generator.sv
// MT19937 generator with array seeding, 32-bit word draws and version 4 UUID draws.
// Depends on mtuuid_pkg and mtuuid_ram.
// A key load writes the key store directly on acceptance; a seed runs a linear fill of 623 words,
// a key mixing pass of max(624, key length) steps and a final pass of 623 steps, using the shared
// 32x32 multiplier and the single state memory port. A draw tempers one state word per 32-bit word;
// whenever the 624 words are used up, a regeneration pass with two reads per word runs first.
// One request is handled at a time. Reset is asynchronous and active low; it clears the control
// state and the seeded flag and sets key length to 1000; memory contents are not cleared.
`timescale 1ns / 1ps
module mt19937_uuid_v4_generator #(
  parameter int unsigned KEY_DEPTH = mtuuid_pkg::KEY_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [9:0]  key_index_i,
  input  logic [31:0] key_word_i,
  input  logic [31:0] seed_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_o,
  output logic        last_o,
  output logic        error_o,
  input  logic        cfg_we_i,
  input  logic [mtuuid_pkg::KLEN_W-1:0] cfg_wdata_i
);

  import mtuuid_pkg::*;

  localparam int unsigned KA_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_A_MUL, ST_A_WR,
    ST_B_RD, ST_B_WR,
    ST_C_RD, ST_C_WR,
    ST_FIN,
    ST_DR_CHK, ST_DR_GET,
    ST_RG_INIT, ST_RG_LD, ST_RG_RN, ST_RG_RM, ST_RG_WR,
    ST_OUT_HI, ST_OUT_LO
  } state_e;

  state_e           state_q;
  logic [TW_AW-1:0] i_q;
  logic [TW_AW-1:0] widx_q;
  logic [KLEN_W-1:0] klen_q, klen_eff_q, j_q, kcnt_q;
  logic             seeded_q;
  logic [31:0]      seed_q, prev_q, prod_q, cur_q, nxt_q;
  logic [63:0]      hi_q, lo_q;
  logic [1:0]       cnt_q;
  logic             uuid_q, err_q;

  // State memory controls.
  logic             tw_we;
  logic [TW_AW-1:0] tw_waddr, tw_raddr;
  logic [31:0]      tw_wdata, tw_rdata;

  // Key memory controls.
  logic             key_we;
  logic [KA_W-1:0]  key_waddr, key_raddr;
  logic [31:0]      key_rdata, kidx_ext, j_ext;

  // Shared multiplier operands.
  logic [31:0] mul_op, mul_k, mul_res;
  logic [31:0] b_word, c_word, rg_y, rg_word, tmp_word;
  logic [TW_AW-1:0] i_inc, rg_nxt, rg_far;
  logic [KLEN_W-1:0] j_inc;
  logic        accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  // Key store write on a load request inside the store.
  assign kidx_ext  = 32'(key_index_i);
  assign key_we    = accept && (func_i == FUNC_LOAD) && (kidx_ext < KEY_DEPTH);
  assign key_waddr = kidx_ext[KA_W-1:0];
  assign j_ext     = 32'(j_q);
  assign key_raddr = j_ext[KA_W-1:0];

  // Index arithmetic for seeding and regeneration.
  assign i_inc  = (i_q == TW_AW'(STATE_WORDS - 1)) ? TW_AW'(1) : i_q + TW_AW'(1);
  assign j_inc  = ((j_q + KLEN_W'(1)) >= klen_eff_q) ? '0 : j_q + KLEN_W'(1);
  assign rg_nxt = (i_q == TW_AW'(STATE_WORDS - 1)) ? '0 : i_q + TW_AW'(1);
  assign rg_far = (i_q < TW_AW'(STATE_WORDS - SHIFT_OFFSET)) ? i_q + TW_AW'(SHIFT_OFFSET)
                                                             : i_q - TW_AW'(STATE_WORDS - SHIFT_OFFSET);

  // One multiplier serves all three seeding recurrences.
  assign mul_op = prev_q ^ (prev_q >> 30);
  always_comb begin
    unique case (state_q)
      ST_B_RD: mul_k = MUL_KEY;
      ST_C_RD: mul_k = MUL_MIX;
      default: mul_k = MUL_LINEAR;
    endcase
  end
  assign mul_res = mul_op * mul_k;

  // New words for each pass.
  assign b_word   = (tw_rdata ^ prod_q) + key_rdata + j_ext;
  assign c_word   = (tw_rdata ^ prod_q) - 32'(i_q);
  assign rg_y     = {cur_q[31], nxt_q[30:0]};
  assign rg_word  = tw_rdata ^ (rg_y >> 1) ^ (rg_y[0] ? TWIST_A : '0);
  assign tmp_word = temper(tw_rdata);

  // State memory port selection.
  always_comb begin
    tw_we    = 1'b0;
    tw_waddr = i_q;
    tw_wdata = prod_q + 32'(i_q);
    tw_raddr = i_q;
    unique case (state_q)
      ST_A_WR: tw_we = 1'b1;
      ST_B_WR: begin
        tw_we    = 1'b1;
        tw_wdata = b_word;
      end
      ST_C_WR: begin
        tw_we    = 1'b1;
        tw_wdata = c_word;
      end
      ST_FIN: begin
        tw_we    = 1'b1;
        tw_waddr = '0;
        tw_wdata = HEAD_WORD;
      end
      ST_RG_INIT: tw_raddr = '0;
      ST_RG_RN:   tw_raddr = rg_nxt;
      ST_RG_RM:   tw_raddr = rg_far;
      ST_RG_WR: begin
        tw_we    = 1'b1;
        tw_wdata = rg_word;
      end
      ST_DR_CHK: tw_raddr = widx_q;
      default: ;
    endcase
  end

  mtuuid_ram #(.WIDTH(WORD_W), .DEPTH(STATE_WORDS), .AW(TW_AW)) u_tw_ram (
    .clk_i   (clk_i),
    .we_i    (tw_we),
    .waddr_i (tw_waddr),
    .wdata_i (tw_wdata),
    .raddr_i (tw_raddr),
    .rdata_o (tw_rdata)
  );

  mtuuid_ram #(.WIDTH(WORD_W), .DEPTH(KEY_DEPTH), .AW(KA_W)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_word_i),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  // Sequencer with its registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      widx_q   <= TW_AW'(STATE_WORDS);
      seeded_q <= 1'b0;
      klen_q   <= KLEN_RST;
    end else begin
      if (cfg_we_i) begin
        klen_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            priority if (func_i == FUNC_SEED) begin
              seed_q <= seed_value_i;
              prev_q <= seed_value_i;
              i_q    <= TW_AW'(1);
              if (klen_q == '0) begin
                klen_eff_q <= KLEN_W'(1);
              end else if (32'(klen_q) > KEY_DEPTH) begin
                klen_eff_q <= KLEN_W'(KEY_DEPTH);
              end else begin
                klen_eff_q <= klen_q;
              end
              state_q <= ST_A_MUL;
            end else if (func_i == FUNC_LOAD) begin
              state_q <= ST_IDLE;
            end else if (!seeded_q) begin
              lo_q    <= '0;
              uuid_q  <= 1'b0;
              err_q   <= 1'b1;
              state_q <= ST_OUT_LO;
            end else begin
              uuid_q  <= (func_i == FUNC_UUID);
              cnt_q   <= (func_i == FUNC_UUID) ? 2'd3 : 2'd0;
              err_q   <= 1'b0;
              state_q <= ST_DR_CHK;
            end
          end
        end
        // Linear fill of the state words.
        ST_A_MUL: begin
          prod_q  <= mul_res;
          state_q <= ST_A_WR;
        end
        ST_A_WR: begin
          prev_q <= tw_wdata;
          if (i_q == TW_AW'(STATE_WORDS - 1)) begin
            i_q     <= TW_AW'(1);
            j_q     <= '0;
            prev_q  <= seed_q;
            kcnt_q  <= (klen_eff_q > KLEN_W'(STATE_WORDS)) ? klen_eff_q : KLEN_W'(STATE_WORDS);
            state_q <= ST_B_RD;
          end else begin
            i_q     <= i_q + TW_AW'(1);
            state_q <= ST_A_MUL;
          end
        end
        // Key mixing pass.
        ST_B_RD: begin
          prod_q  <= mul_res;
          state_q <= ST_B_WR;
        end
        ST_B_WR: begin
          prev_q <= b_word;
          i_q    <= i_inc;
          j_q    <= j_inc;
          if (kcnt_q == KLEN_W'(1)) begin
            kcnt_q  <= KLEN_W'(STATE_WORDS - 1);
            state_q <= ST_C_RD;
          end else begin
            kcnt_q  <= kcnt_q - KLEN_W'(1);
            state_q <= ST_B_RD;
          end
        end
        // Final mixing pass.
        ST_C_RD: begin
          prod_q  <= mul_res;
          state_q <= ST_C_WR;
        end
        ST_C_WR: begin
          prev_q <= c_word;
          i_q    <= i_inc;
          if (kcnt_q == KLEN_W'(1)) begin
            state_q <= ST_FIN;
          end else begin
            kcnt_q  <= kcnt_q - KLEN_W'(1);
            state_q <= ST_C_RD;
          end
        end
        ST_FIN: begin
          widx_q   <= TW_AW'(STATE_WORDS);
          seeded_q <= 1'b1;
          state_q  <= ST_IDLE;
        end
        // Word draws, regenerating first when the words are used up.
        ST_DR_CHK: begin
          if (widx_q == TW_AW'(STATE_WORDS)) begin
            state_q <= ST_RG_INIT;
          end else begin
            widx_q  <= widx_q + TW_AW'(1);
            state_q <= ST_DR_GET;
          end
        end
        ST_DR_GET: begin
          hi_q <= {hi_q[31:0], lo_q[63:32]};
          lo_q <= {lo_q[31:0], tmp_word};
          if (cnt_q == 2'd0) begin
            state_q <= uuid_q ? ST_OUT_HI : ST_OUT_LO;
          end else begin
            cnt_q   <= cnt_q - 2'd1;
            state_q <= ST_DR_CHK;
          end
        end
        // Regeneration of all state words.
        ST_RG_INIT: begin
          i_q     <= '0;
          state_q <= ST_RG_LD;
        end
        ST_RG_LD: begin
          cur_q   <= tw_rdata;
          state_q <= ST_RG_RN;
        end
        ST_RG_RN: state_q <= ST_RG_RM;
        ST_RG_RM: begin
          nxt_q   <= tw_rdata;
          state_q <= ST_RG_WR;
        end
        ST_RG_WR: begin
          cur_q <= nxt_q;
          if (i_q == TW_AW'(STATE_WORDS - 1)) begin
            widx_q  <= '0;
            state_q <= ST_DR_CHK;
          end else begin
            i_q     <= i_q + TW_AW'(1);
            state_q <= ST_RG_RN;
          end
        end
        // Result delivery.
        ST_OUT_HI: begin
          if (out_ready_i) begin
            state_q <= ST_OUT_LO;
          end
        end
        ST_OUT_LO: begin
          if (out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Output fields, with the version and variant bits on UUID halves.
  assign out_valid_o = (state_q == ST_OUT_HI) || (state_q == ST_OUT_LO);
  assign last_o      = (state_q == ST_OUT_LO);
  assign error_o     = err_q;
  always_comb begin
    if (state_q == ST_OUT_HI) begin
      value_o = {hi_q[63:56], 4'h4, hi_q[51:0]};
    end else if (uuid_q) begin
      value_o = {lo_q[63:8], 2'b10, lo_q[5:0]};
    end else begin
      value_o = {32'd0, lo_q[31:0]};
    end
  end

endmodule

// File: rtl/mtuuid_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mtuuid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
